### src/srt_pkg.sv
// Shared types and constants for the sequenced record table.
// Holds result codes, controller states and the command/status structs.
// No dependencies.
package srt_pkg;

    localparam int KEY_W           = 16;
    localparam int SEQ_W           = 8;
    localparam int IN_DATA_W       = 64;
    localparam int STATUS_W        = 3;
    localparam int SLOT_W          = 4;
    localparam int FILL_W          = 5;
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_DATA_WIDTH  = 64;

    localparam logic [SEQ_W-1:0] SEQ_WRAP = 8'hFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_STALE    = 3'd2,
        ST_FULL     = 3'd3,
        ST_PURGED   = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic rd_en;
        logic rd_next;
        logic inc_idx;
        logic mark_found;
        logic decide;
        logic shift_wr;
        logic dec_count;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic hit;
        logic last;
        logic need_shift;
        logic tail;
        logic out_free;
    } dp_stat_t;

endpackage

### src/sequenced_record_table.sv
// Sequenced record table: a compact table of up to TABLE_DEPTH records, each a
// 16-bit key, an 8-bit sequence number and a payload, held in one single-port
// memory with registered read. An update beat searches the filled entries one
// at a time, a read then a key check per entry, then overwrites (newer sequence,
// or stored 0xFF), ignores as stale, appends at the tail, or drops when full. A
// purge beat removes the match and moves each later entry down, a read then a
// write per moved entry. A purge that finds its key at entry F of N filled
// entries has searched F+1 entries and moves the N-1-F entries behind it, so
// search and move together walk each filled entry once. One item is worked at
// a time; a result waiting in the output register does not stop the next item
// from being accepted and searched.
module sequenced_record_table #(
    parameter int TABLE_DEPTH = srt_pkg::DEF_TABLE_DEPTH,
    parameter int DATA_WIDTH  = srt_pkg::DEF_DATA_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [srt_pkg::KEY_W-1:0]       entry_key,
    input  logic [srt_pkg::SEQ_W-1:0]       sequence_req,
    input  logic [srt_pkg::IN_DATA_W-1:0]   record_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [srt_pkg::STATUS_W-1:0]    status,
    output logic [srt_pkg::SLOT_W-1:0]      slot,
    output logic [srt_pkg::FILL_W-1:0]      fill_count
);

    srt_pkg::ctrl_cmd_t cmd;
    srt_pkg::dp_stat_t  stat;

    srt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .entry_key    (entry_key),
        .sequence_req (sequence_req),
        .record_data  (record_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .slot         (slot),
        .fill_count   (fill_count)
    );

endmodule

### src/srt_ctrl.sv
// Controller state machine for the sequenced record table.
// Sequences search, decide, purge shift and result beat; depends on srt_pkg.
module srt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  srt_pkg::dp_stat_t  stat,
    output srt_pkg::ctrl_cmd_t cmd
);

    srt_pkg::state_t state_reg;
    srt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.count_zero ? srt_pkg::S_DECIDE : srt_pkg::S_LOOK;
                end
            end
            srt_pkg::S_LOOK:
            begin
                state_next = srt_pkg::S_CHECK;
            end
            srt_pkg::S_CHECK:
            begin
                if (stat.hit || stat.last)
                begin
                    state_next = srt_pkg::S_DECIDE;
                end
                else
                begin
                    state_next = srt_pkg::S_LOOK;
                end
            end
            srt_pkg::S_DECIDE:
            begin
                state_next = stat.need_shift ? srt_pkg::S_SHIFT_RD : srt_pkg::S_RESULT;
            end
            srt_pkg::S_SHIFT_RD:
            begin
                state_next = srt_pkg::S_SHIFT_WR;
            end
            srt_pkg::S_SHIFT_WR:
            begin
                state_next = stat.tail ? srt_pkg::S_RESULT : srt_pkg::S_SHIFT_RD;
            end
            srt_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = srt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = srt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            srt_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            srt_pkg::S_LOOK:
            begin
                cmd.rd_en = 1'b1;
            end
            srt_pkg::S_CHECK:
            begin
                cmd.mark_found = stat.hit;
                cmd.inc_idx    = !stat.hit && !stat.last;
            end
            srt_pkg::S_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            srt_pkg::S_SHIFT_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_next = 1'b1;
            end
            srt_pkg::S_SHIFT_WR:
            begin
                cmd.shift_wr  = 1'b1;
                cmd.dec_count = stat.tail;
            end
            srt_pkg::S_RESULT:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### src/srt_dpath.sv
// Datapath for the sequenced record table: record memory, scan index,
// fill count, decision logic and output register. Depends on srt_pkg.
module srt_dpath #(
    parameter int TABLE_DEPTH = srt_pkg::DEF_TABLE_DEPTH,
    parameter int DATA_WIDTH  = srt_pkg::DEF_DATA_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  srt_pkg::ctrl_cmd_t              cmd,
    output srt_pkg::dp_stat_t               stat,
    input  logic                            op,
    input  logic [srt_pkg::KEY_W-1:0]       entry_key,
    input  logic [srt_pkg::SEQ_W-1:0]       sequence_req,
    input  logic [srt_pkg::IN_DATA_W-1:0]   record_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [srt_pkg::STATUS_W-1:0]    status,
    output logic [srt_pkg::SLOT_W-1:0]      slot,
    output logic [srt_pkg::FILL_W-1:0]      fill_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int REC_W = srt_pkg::KEY_W + srt_pkg::SEQ_W + DATA_WIDTH;

    logic [REC_W-1:0] mem [TABLE_DEPTH];

    logic                          op_reg;
    logic [srt_pkg::KEY_W-1:0]     key_reg;
    logic [srt_pkg::SEQ_W-1:0]     seq_reg;
    logic [DATA_WIDTH-1:0]         data_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          found_reg;
    logic [REC_W-1:0]              rd_data_reg;
    srt_pkg::status_t              res_status_reg;
    logic [IDX_W-1:0]              res_slot_reg;
    logic                          out_valid_reg;
    logic [srt_pkg::STATUS_W-1:0]  out_status_reg;
    logic [srt_pkg::SLOT_W-1:0]    out_slot_reg;
    logic [srt_pkg::FILL_W-1:0]    out_fill_reg;

    logic [srt_pkg::KEY_W-1:0]     rd_key;
    logic [srt_pkg::SEQ_W-1:0]     rd_seq;
    logic [CNT_W-1:0]              idx_inc;
    logic [CNT_W:0]                idx_plus2;
    logic [IDX_W-1:0]              rd_addr;
    logic                          upd_ok;
    logic                          full;
    logic                          is_update;
    logic                          is_insert;
    logic                          purge_last;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic [REC_W-1:0]              wr_rec;

    assign rd_key     = rd_data_reg[REC_W-1 -: srt_pkg::KEY_W];
    assign rd_seq     = rd_data_reg[DATA_WIDTH +: srt_pkg::SEQ_W];
    assign idx_inc    = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_plus2  = (CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(2);
    assign rd_addr    = cmd.rd_next ? (idx_reg + IDX_W'(1)) : idx_reg;
    assign upd_ok     = (rd_seq < seq_reg) || (rd_seq == srt_pkg::SEQ_WRAP);
    assign full       = (count_reg == CNT_W'(TABLE_DEPTH));
    assign is_update  = cmd.decide && !op_reg && found_reg && upd_ok;
    assign is_insert  = cmd.decide && !op_reg && !found_reg && !full;
    assign purge_last = cmd.decide && op_reg && found_reg && (idx_inc == count_reg);

    assign stat.count_zero = (count_reg == '0);
    assign stat.hit        = (rd_key == key_reg);
    assign stat.last       = (idx_inc == count_reg);
    assign stat.need_shift = op_reg && found_reg && (idx_inc != count_reg);
    assign stat.tail       = (idx_plus2 >= (CNT_W + 1)'(count_reg));
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_rec  = {key_reg, seq_reg, data_reg};
        if (is_update)
        begin
            wr_en = 1'b1;
        end
        else if (is_insert)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
        end
        else if (cmd.shift_wr)
        begin
            wr_en  = 1'b1;
            wr_rec = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_rec;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg   <= op;
            key_reg  <= entry_key;
            seq_reg  <= sequence_req;
            data_reg <= record_data[DATA_WIDTH-1:0];
        end
        if (cmd.decide)
        begin
            if (!op_reg)
            begin
                if (found_reg)
                begin
                    res_status_reg <= upd_ok ? srt_pkg::ST_UPDATED : srt_pkg::ST_STALE;
                    res_slot_reg   <= upd_ok ? idx_reg : '0;
                end
                else
                begin
                    res_status_reg <= full ? srt_pkg::ST_FULL : srt_pkg::ST_INSERTED;
                    res_slot_reg   <= full ? '0 : count_reg[IDX_W-1:0];
                end
            end
            else
            begin
                res_status_reg <= found_reg ? srt_pkg::ST_PURGED : srt_pkg::ST_NOTFOUND;
                res_slot_reg   <= found_reg ? idx_reg : '0;
            end
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= srt_pkg::SLOT_W'(res_slot_reg);
            out_fill_reg   <= srt_pkg::FILL_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch_in)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.inc_idx || cmd.shift_wr)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (cmd.mark_found)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (is_insert)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (purge_last || cmd.dec_count)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot       = out_slot_reg;
    assign fill_count = out_fill_reg;

endmodule

### src/srt_checker.sv
// Port-level checks for the sequenced record table, bound to the top level.
// Depends on srt_pkg.
module srt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            op,
    input logic [srt_pkg::KEY_W-1:0]       entry_key,
    input logic [srt_pkg::SEQ_W-1:0]       sequence_req,
    input logic [srt_pkg::IN_DATA_W-1:0]   record_data,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [srt_pkg::STATUS_W-1:0]    status,
    input logic [srt_pkg::SLOT_W-1:0]      slot,
    input logic [srt_pkg::FILL_W-1:0]      fill_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(status) && $stable(slot) && $stable(fill_count))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= srt_pkg::ST_NOTFOUND)
        else $error("undefined status code");

    a_untouched_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == srt_pkg::ST_STALE || status == srt_pkg::ST_FULL ||
                      status == srt_pkg::ST_NOTFOUND) |-> slot == '0)
        else $error("nonzero slot on untouched result");

    a_insert_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == srt_pkg::ST_INSERTED |->
            fill_count[srt_pkg::SLOT_W-1:0] == slot + srt_pkg::SLOT_W'(1))
        else $error("insert slot is not the tail");

endmodule

bind sequenced_record_table srt_checker u_srt_checker (.*);
